/* rtl/core/crc32c_combine_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-32C combine unit.
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRC32C_COMBINE_UNIT_ASSERT_SVH
`define CRC32C_COMBINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc32c_combine_unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc32c_combine_unit: assertion failed");

`endif

/* rtl/core/crcc_pkg.sv */
// ----------------------------------------------------------------------------
// crcc_pkg
// Types, constants and the zero-byte operator table of the CRC-32C combine
// unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crcc_pkg;

  // Field widths.
  localparam int CRC_W       = 32;
  localparam int LEN_FIELD_W = 32;
  localparam int BYTE_W      = 8;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;

  // Number of low length bits that take part in the advance.
  localparam int LENGTH_WIDTH = 32;
  // Length bits above the field width are always zero, so steps stop there.
  localparam int LEN_STEPS = (LENGTH_WIDTH < LEN_FIELD_W) ? LENGTH_WIDTH : LEN_FIELD_W;
  localparam int STEP_W    = (LEN_STEPS > 1) ? $clog2(LEN_STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LEN_STEPS - 1);

  // Stream widths: tdata packs first_crc, second_crc, second_length.
  localparam int IN_DATA_W  = 2 * CRC_W + LEN_FIELD_W;
  localparam int OUT_DATA_W = CRC_W;

  // A 32x32 GF(2) matrix stored as 32 columns, one per input bit.
  typedef logic [CRC_W-1:0][CRC_W-1:0] mat_t;
  // Operator for 2**i zero bytes at entry i.
  typedef mat_t [LEN_STEPS-1:0] op_table_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              step;
    logic              commit;
    logic [STEP_W-1:0] idx;
  } cmd_t;

  // Multiplies a matrix by a vector over GF(2).
  function automatic logic [CRC_W-1:0] gf_apply(input mat_t cols, input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int b = 0; b < CRC_W; b++) begin
      if (v[b]) begin
        acc = acc ^ cols[b];
      end
    end
    return acc;
  endfunction

  // Builds the table of repeated squares of the one-zero-byte operator.
  function automatic op_table_t build_op_table();
    op_table_t        tbl;
    mat_t             op;
    mat_t             sq;
    logic [CRC_W-1:0] c;
    for (int n = 0; n < CRC_W; n++) begin
      c = '0;
      c[n] = 1'b1;
      for (int k = 0; k < BYTE_W; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      op[n] = c;
    end
    for (int i = 0; i < LEN_STEPS; i++) begin
      tbl[i] = op;
      for (int b = 0; b < CRC_W; b++) begin
        sq[b] = gf_apply(op, op[b]);
      end
      op = sq;
    end
    return tbl;
  endfunction

  localparam op_table_t OP_TABLE = build_op_table();

endpackage

/* rtl/core/crcc_ctrl.sv */
// ----------------------------------------------------------------------------
// crcc_ctrl
// Controller of the combine unit: sequences the length-bit steps and owns
// both stream handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output crcc_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [crcc_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        slot_free;
  logic                        commit;

  // The result register can take a new value once it is empty or being read.
  assign slot_free = !out_valid_r || out_tready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == crcc_pkg::LAST_STEP) begin
          if (slot_free) begin
            commit    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag: a commit wins over a read in the same cycle.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Handshakes and datapath commands.
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  assign cmd.load   = in_tvalid && (state_r == ST_IDLE);
  assign cmd.step   = (state_r == ST_RUN);
  assign cmd.commit = commit;
  assign cmd.idx    = cnt_r;

endmodule

/* rtl/core/crcc_datapath.sv */
// ----------------------------------------------------------------------------
// crcc_datapath
// Datapath of the combine unit: working CRC, length shift register and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcc_datapath (
  input  logic                              clk,
  input  crcc_pkg::cmd_t                    cmd,
  input  logic [crcc_pkg::IN_DATA_W-1:0]    in_data,
  output logic [crcc_pkg::OUT_DATA_W-1:0]   out_data
);

  logic [crcc_pkg::CRC_W-1:0]     crc_r, crc_nxt;
  logic [crcc_pkg::CRC_W-1:0]     second_r;
  logic [crcc_pkg::LEN_STEPS-1:0] len_r;
  logic [crcc_pkg::CRC_W-1:0]     res_r;
  logic [crcc_pkg::CRC_W-1:0]     advanced;

  // One step: apply the operator for 2**idx zero bytes when the length bit is set.
  assign advanced = crcc_pkg::gf_apply(crcc_pkg::OP_TABLE[cmd.idx], crc_r);
  assign crc_nxt  = len_r[0] ? advanced : crc_r;

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      crc_r    <= in_data[crcc_pkg::CRC_W-1:0];
      second_r <= in_data[2*crcc_pkg::CRC_W-1:crcc_pkg::CRC_W];
      len_r    <= in_data[2*crcc_pkg::CRC_W +: crcc_pkg::LEN_STEPS];
    end else if (cmd.step) begin
      crc_r <= crc_nxt;
      len_r <= len_r >> 1;
    end
  end

  // Result register, loaded either straight from the last step or while holding.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= (cmd.step ? crc_nxt : crc_r) ^ second_r;
    end
  end

  assign out_data = res_r;

endmodule

/* rtl/core/crc32c_combine_unit.sv */
// CRC-32C combine unit: result = first_crc advanced by second_length zero bytes, XOR second_crc.
// The advance takes one length bit per cycle, lowest bit first, while the controller is in ST_RUN.
// Items are processed one at a time on the single shared operator-apply step.
// A finished result waits in an output register; a new item starts once it is committed.
// Reset: rst_n is synchronous and active low; it clears the controller and out_tvalid.
// ----------------------------------------------------------------------------
// crc32c_combine_unit
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "crc32c_combine_unit_assert.svh"

module crc32c_combine_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: first_crc[31:0], second_crc[63:32], second_length[95:64].
  input  logic [crcc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: combined_crc[31:0].
  output logic [crcc_pkg::OUT_DATA_W-1:0]  out_tdata
);

  crcc_pkg::cmd_t cmd;

  // Controller.
  crcc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Datapath.
  crcc_datapath u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

  // A request puts the unit to work: it is busy in the following cycle.
  `CRCC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // A result only appears at the end of work in progress.
  `CRCC_ASSERT_SAME(a_result_from_work, $rose(out_tvalid), $past(!in_tready))
  // A result is only withdrawn after it has been taken.
  `CRCC_ASSERT_SAME(a_result_taken, $fell(out_tvalid), $past(out_tready))
  // Loading and stepping never coincide.
  `CRCC_ASSERT_SAME(a_load_xor_step, cmd.load, !cmd.step && !cmd.commit)

endmodule
